FILE: src/rcc_pkg.sv
// Package for the rectangle/circle collision test.
// Holds the flag bundle that travels beside the distance data between pipeline stages.
// No dependencies.
package rcc_pkg;

    // Per-request flags carried down the pipeline
    typedef struct packed {
        logic valid;       // a request occupies this stage
        logic bound_pass;  // circle's bounding square overlaps the rectangle
        logic edge_hit;    // center projects onto the left or top edge span
    } rcc_flags_t;

endpackage

FILE: src/rect_circle_collision_test.sv
// Rectangle/circle collision test, top level.
// Offset and bounding stage here; corner distance stages in rcc_corner_check. Uses rcc_pkg.
//
// Usage:
//   A request (rectangle corner, width, height, circle center, radius) is taken
//   at each rising edge where start is high and busy is low. busy is always low:
//   the pipeline takes one request every cycle with no gaps.
//   Each request yields one result: done pulses high for one cycle with hit
//   valid in that same cycle, once the request has passed the stage 1, stage 2
//   and stage 3 registers (results come out in request order).
//   Pipeline: stage 1 forms corner offsets, their magnitudes, the bounding
//   square overlap and the edge projection flags; stage 2 squares the offsets
//   and the radius (five multipliers of COORD_BITS-1 bits); stage 3 sums,
//   compares with r*r and registers hit.
//   Throughput: one request per cycle, set by the fully pipelined multipliers.
//   Reset clears the stage valid bits, so no done pulse follows reset until a
//   new request enters. The receiver cannot stall; results are shown once.
module rect_circle_collision_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [COORD_BITS-1:0]   rect_left,
    input  logic [COORD_BITS-1:0]   rect_top,
    input  logic [COORD_BITS-2:0]   rect_width,
    input  logic [COORD_BITS-2:0]   rect_height,
    input  logic [COORD_BITS-1:0]   circle_x,
    input  logic [COORD_BITS-1:0]   circle_y,
    input  logic [COORD_BITS-2:0]   radius,
    output logic                    done,
    output logic                    hit
);

    localparam int DW = COORD_BITS + 2;
    localparam int LW = COORD_BITS - 1;

    logic signed [DW-1:0] rx, ry, cx, cy, w, h, r;
    logic signed [DW-1:0] rx_w, ry_h;
    logic signed [DW-1:0] dx0, dx1, dy0, dy1;
    logic signed [DW-1:0] ax0, ax1, ay0, ay1;
    logic                 nx0, nx1, ny0, ny1;
    logic                 bound_pass, vproj, hproj;
    logic                 accept;

    rcc_pkg::rcc_flags_t  flags_reg, flags_next;
    logic [LW-1:0]        abs_x0_reg, abs_x1_reg, abs_y0_reg, abs_y1_reg, rad_reg;
    logic [3:0]           near_reg, near_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage 1: offsets, magnitudes and flags
    always_comb
    begin
        rx = $signed({{2{rect_left[COORD_BITS-1]}}, rect_left});
        ry = $signed({{2{rect_top[COORD_BITS-1]}}, rect_top});
        cx = $signed({{2{circle_x[COORD_BITS-1]}}, circle_x});
        cy = $signed({{2{circle_y[COORD_BITS-1]}}, circle_y});
        w  = $signed({3'b000, rect_width});
        h  = $signed({3'b000, rect_height});
        r  = $signed({3'b000, radius});

        rx_w = rx + w;
        ry_h = ry + h;

        // strict overlap of the circle's bounding square with the rectangle
        bound_pass = !((rx >= cx + r) || (rx_w <= cx - r) ||
                       (ry >= cy + r) || (ry_h <= cy - r));

        // zero edge length counts as a projection hit
        vproj = (rect_height == '0) || ((cy >= ry) && (cy <= ry_h));
        hproj = (rect_width == '0) || ((cx >= rx) && (cx <= rx_w));

        dx0 = rx - cx;
        dx1 = rx_w - cx;
        dy0 = ry - cy;
        dy1 = ry_h - cy;
        ax0 = dx0[DW-1] ? -dx0 : dx0;
        ax1 = dx1[DW-1] ? -dx1 : dx1;
        ay0 = dy0[DW-1] ? -dy0 : dy0;
        ay1 = dy1[DW-1] ? -dy1 : dy1;
        nx0 = ax0 <= r;
        nx1 = ax1 <= r;
        ny0 = ay0 <= r;
        ny1 = ay1 <= r;

        near_next = {nx1 && ny1, nx1 && ny0, nx0 && ny1, nx0 && ny0};

        flags_next.valid      = accept;
        flags_next.bound_pass = bound_pass;
        flags_next.edge_hit   = vproj || hproj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // magnitudes only matter when within the radius, so LW bits suffice
    always_ff @(posedge clk)
    begin
        near_reg   <= near_next;
        abs_x0_reg <= ax0[LW-1:0];
        abs_x1_reg <= ax1[LW-1:0];
        abs_y0_reg <= ay0[LW-1:0];
        abs_y1_reg <= ay1[LW-1:0];
        rad_reg    <= radius;
    end

    rcc_corner_check #(
        .COORD_BITS (COORD_BITS)
    ) u_corner (
        .clk         (clk),
        .rst_n       (rst_n),
        .flags_in    (flags_reg),
        .abs_x0      (abs_x0_reg),
        .abs_x1      (abs_x1_reg),
        .abs_y0      (abs_y0_reg),
        .abs_y1      (abs_y1_reg),
        .rad         (rad_reg),
        .corner_near (near_reg),
        .done        (done),
        .hit         (hit)
    );

endmodule

FILE: src/rcc_corner_check.sv
// Corner distance check: squares the per-axis corner offsets and compares with r*r.
// Two register stages (squares, then final decision). Depends on rcc_pkg.
module rcc_corner_check #(
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rcc_pkg::rcc_flags_t     flags_in,
    input  logic [COORD_BITS-2:0]   abs_x0,
    input  logic [COORD_BITS-2:0]   abs_x1,
    input  logic [COORD_BITS-2:0]   abs_y0,
    input  logic [COORD_BITS-2:0]   abs_y1,
    input  logic [COORD_BITS-2:0]   rad,
    input  logic [3:0]              corner_near,
    output logic                    done,
    output logic                    hit
);

    localparam int SQW  = 2 * (COORD_BITS - 1);
    localparam int SUMW = SQW + 1;

    rcc_pkg::rcc_flags_t flags_reg;
    logic [3:0]          near_reg;
    logic [SQW-1:0]      sq_x0_reg, sq_x1_reg, sq_y0_reg, sq_y1_reg, rr_reg;

    logic [SUMW-1:0]     sum_00, sum_01, sum_10, sum_11, rr_ext;
    logic                corner_hit;
    logic                done_reg, hit_reg, hit_next;

    // Stage 2: squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_in;
        end
    end

    always_ff @(posedge clk)
    begin
        near_reg  <= corner_near;
        sq_x0_reg <= SQW'(abs_x0) * SQW'(abs_x0);
        sq_x1_reg <= SQW'(abs_x1) * SQW'(abs_x1);
        sq_y0_reg <= SQW'(abs_y0) * SQW'(abs_y0);
        sq_y1_reg <= SQW'(abs_y1) * SQW'(abs_y1);
        rr_reg    <= SQW'(rad) * SQW'(rad);
    end

    // Stage 3: sum and compare per corner
    always_comb
    begin
        rr_ext = {1'b0, rr_reg};
        sum_00 = {1'b0, sq_x0_reg} + {1'b0, sq_y0_reg};
        sum_01 = {1'b0, sq_x0_reg} + {1'b0, sq_y1_reg};
        sum_10 = {1'b0, sq_x1_reg} + {1'b0, sq_y0_reg};
        sum_11 = {1'b0, sq_x1_reg} + {1'b0, sq_y1_reg};
        corner_hit = (near_reg[0] && (sum_00 <= rr_ext)) ||
                     (near_reg[1] && (sum_01 <= rr_ext)) ||
                     (near_reg[2] && (sum_10 <= rr_ext)) ||
                     (near_reg[3] && (sum_11 <= rr_ext));
        hit_next = flags_reg.bound_pass && (corner_hit || flags_reg.edge_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= flags_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

FILE: sim/rect_circle_collision_test_tb.sv
// Self-checking testbench for rect_circle_collision_test: a directed table, then random
// rectangle/circle requests, each checked against a typed expectation or a behavioral collision predictor.
// Depends only on the RTL top level rect_circle_collision_test.
module rect_circle_collision_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS   = 16;
    localparam int LATENCY      = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 1900;
    localparam int NUM_PHASES   = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-2:0] len_t;

    typedef struct {
        coord_t rl;
        coord_t rt;
        len_t   w;
        len_t   h;
        coord_t cx;
        coord_t cy;
        len_t   r;
    } query_t;

    typedef struct {
        query_t q;
        bit     typed;
        bit     hit;
    } dir_row_t;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t rect_left;
    coord_t rect_top;
    len_t   rect_width;
    len_t   rect_height;
    coord_t circle_x;
    coord_t circle_y;
    len_t   radius;
    logic   done;
    logic   hit;

    logic   req_hit;
    logic   hit_expected[$];
    int     mismatch_count;
    int     requests_taken;
    int     results_seen;
    int     hits_seen;
    int     cycle_count;

    rect_circle_collision_test #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .rect_left(rect_left),
        .rect_top(rect_top),
        .rect_width(rect_width),
        .rect_height(rect_height),
        .circle_x(circle_x),
        .circle_y(circle_y),
        .radius(radius),
        .done(done),
        .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int sign_of(longint a);
        return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
    endfunction

    function automatic bit corner_within(longint cx, longint cy, longint r,
                                         longint px, longint py);
        longint dx;
        longint dy;
        dx = px - cx;
        dy = py - cy;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx > r || dy > r)
            return 1'b0;
        return (dx * dx + dy * dy) <= r * r;
    endfunction

    function automatic logic predict_hit(query_t q);
        longint rx;
        longint ry;
        longint w;
        longint h;
        longint cx;
        longint cy;
        longint r;
        int     sw;
        int     sh;
        int     vert;
        int     horz;
        rx = longint'(q.rl);
        ry = longint'(q.rt);
        w  = longint'(q.w);
        h  = longint'(q.h);
        cx = longint'(q.cx);
        cy = longint'(q.cy);
        r  = longint'(q.r);
        // strict overlap of the circle's bounding square with the rectangle
        if (rx >= cx + r || rx + w <= cx - r || ry >= cy + r || ry + h <= cy - r)
            return 1'b0;
        if (corner_within(cx, cy, r, rx, ry) || corner_within(cx, cy, r, rx, ry + h) ||
            corner_within(cx, cy, r, rx + w, ry) || corner_within(cx, cy, r, rx + w, ry + h))
            return 1'b1;
        if (cx >= rx && cx <= rx + w && cy >= ry && cy <= ry + h)
            return 1'b1;
        // projection onto the left and top edges, decided by signs only
        sh   = sign_of(h);
        sw   = sign_of(w);
        vert = (sign_of(cy - ry) * sh) * (sign_of(cy - ry - h) * sh);
        horz = (sign_of(cx - rx) * sw) * (sign_of(cx - rx - w) * sw);
        return (vert <= 0) || (horz <= 0);
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v > 32767) return coord_t'(32767);
        if (v < -32768) return coord_t'(-32768);
        return coord_t'(v);
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     lim;
        int     rl;
        int     rt;
        int     w;
        int     h;
        int     r;
        int     pick;
        pick = $urandom_range(2);
        lim  = (pick == 0) ? 64 : ((pick == 1) ? 2048 : 32767);
        if ($urandom_range(99) < 15)
        begin
            // noise: every field drawn over its whole range
            q.rl = coord_t'($urandom);
            q.rt = coord_t'($urandom);
            q.w  = len_t'($urandom);
            q.h  = len_t'($urandom);
            q.cx = coord_t'($urandom);
            q.cy = coord_t'($urandom);
            q.r  = len_t'($urandom);
            return q;
        end
        rl = int'($urandom_range(65535)) - 32768;
        rt = int'($urandom_range(65535)) - 32768;
        w  = ($urandom_range(99) < 6) ? 0 : int'($urandom_range(lim));
        h  = ($urandom_range(99) < 6) ? 0 : int'($urandom_range(lim));
        r  = ($urandom_range(99) < 4) ? 0 : int'($urandom_range(lim));
        q.rl = coord_t'(rl);
        q.rt = coord_t'(rt);
        q.w  = len_t'(w);
        q.h  = len_t'(h);
        q.r  = len_t'(r);
        // place the center around the rectangle, reaching just past tangency
        q.cx = clamp_coord(rl + int'($urandom_range(w + 2 * r + 2)) - r - 1);
        q.cy = clamp_coord(rt + int'($urandom_range(h + 2 * r + 2)) - r - 1);
        return q;
    endfunction

    task automatic note_mismatch(string what, logic want, logic got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected=%b actual=%b",
                     cycle_count, what, want, got);
    endtask

    task automatic send_query(query_t q, logic want, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start       = 1'b0;
            rect_left   = coord_t'($urandom);
            rect_top    = coord_t'($urandom);
            rect_width  = len_t'($urandom);
            rect_height = len_t'($urandom);
            circle_x    = coord_t'($urandom);
            circle_y    = coord_t'($urandom);
            radius      = len_t'($urandom);
        end
        @(negedge clk);
        rect_left   = q.rl;
        rect_top    = q.rt;
        rect_width  = q.w;
        rect_height = q.h;
        circle_x    = q.cx;
        circle_y    = q.cy;
        radius      = q.r;
        req_hit     = want;
        start       = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Score results and record accepted requests
    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (hit) hits_seen++;
                if (hit_expected.size() == 0)
                    note_mismatch("unexpected result", 1'bx, hit);
                else
                begin
                    want = hit_expected.pop_front();
                    if (hit !== want)
                        note_mismatch("hit", want, hit);
                end
            end
            if (start && !busy)
            begin
                hit_expected.push_back(req_hit);
                requests_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[rect_circle_collision_test] ERROR");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_table[$];
        int       idle_pct[NUM_PHASES];
        int       phase;
        int       n;
        query_t   q;
        logic     want;

        idle_pct       = '{37, 66, 0};
        mismatch_count = 0;
        requests_taken = 0;
        results_seen   = 0;
        hits_seen      = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        req_hit        = 1'b0;
        rect_left      = '0;
        rect_top       = '0;
        rect_width     = '0;
        rect_height    = '0;
        circle_x       = '0;
        circle_y       = '0;
        radius         = '0;

        // rect left, top, width, height; circle x, y, radius; typed; hit
        dir_table.push_back('{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b0});
        dir_table.push_back('{'{0, 0, 10, 10, 5, 5, 3}, 1'b1, 1'b1});
        // bounding square only touching an edge
        dir_table.push_back('{'{0, 0, 10, 10, -5, 5, 5}, 1'b1, 1'b0});
        dir_table.push_back('{'{0, 0, 10, 10, 15, 5, 5}, 1'b1, 1'b0});
        dir_table.push_back('{'{0, 0, 10, 10, 5, -5, 5}, 1'b1, 1'b0});
        dir_table.push_back('{'{0, 0, 10, 10, 5, 15, 5}, 1'b1, 1'b0});
        // corner exactly on the circle, then just outside
        dir_table.push_back('{'{0, 0, 10, 10, -3, -4, 5}, 1'b1, 1'b1});
        dir_table.push_back('{'{0, 0, 10, 10, -4, -4, 5}, 1'b0, 1'b0});
        dir_table.push_back('{'{0, 0, 10, 10, -3, 5, 4}, 1'b0, 1'b0});
        dir_table.push_back('{'{0, 0, 10, 10, 5, -3, 4}, 1'b0, 1'b0});
        dir_table.push_back('{'{0, 0, 10, 10, 13, 5, 4}, 1'b0, 1'b0});
        // zero radius with the center inside
        dir_table.push_back('{'{0, 0, 10, 10, 5, 5, 0}, 1'b1, 1'b1});
        // degenerate rectangles
        dir_table.push_back('{'{5, 5, 0, 0, 5, 5, 1}, 1'b1, 1'b1});
        dir_table.push_back('{'{0, 0, 0, 10, -3, 20, 4}, 1'b0, 1'b0});
        dir_table.push_back('{'{0, 0, 10, 0, 20, -3, 4}, 1'b0, 1'b0});
        dir_table.push_back('{'{0, 0, 0, 10, -3, 5, 4}, 1'b0, 1'b0});
        // field extremes
        dir_table.push_back('{'{-32768, -32768, 32767, 32767, 32767, 32767, 32767},
                              1'b0, 1'b0});
        dir_table.push_back('{'{32767, 32767, 32767, 32767, -32768, -32768, 32767},
                              1'b1, 1'b0});
        dir_table.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767, 32767},
                              1'b1, 1'b1});
        dir_table.push_back('{'{-32768, -32768, 32767, 32767, -1, -1, 32767},
                              1'b1, 1'b1});
        dir_table.push_back('{'{-32768, -32768, 0, 0, 32767, 32767, 0}, 1'b1, 1'b0});
        dir_table.push_back('{'{-32768, 32767, 32767, 0, 32767, -32768, 32767},
                              1'b0, 1'b0});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                foreach (dir_table[i])
                begin
                    want = dir_table[i].typed ? dir_table[i].hit : predict_hit(dir_table[i].q);
                    send_query(dir_table[i].q, want, idle_pct[phase]);
                end
            end
            for (n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
            begin
                q = random_query();
                send_query(q, predict_hit(q), idle_pct[phase]);
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (hit_expected.size() != 0)
            @(posedge clk);
        // keep waiting to catch stray results
        repeat (LATENCY + 2) @(posedge clk);

        if (hit_expected.size() != 0)
            mismatch_count += hit_expected.size();
        $display("%0d requests taken, %0d results scored, %0d of them hits",
                 requests_taken, results_seen, hits_seen);
        $display("idle mixes of 37, 66 and 0 percent on the request side, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("[rect_circle_collision_test] OK");
        else
            $display("[rect_circle_collision_test] ERROR");
        $finish;
    end

endmodule
